// File: rtl/cpu_load_instruction_executor_defines.svh
// assertion macros used by the executor rtl
`ifndef CPU_LOAD_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define CPU_LOAD_INSTRUCTION_EXECUTOR_DEFINES_SVH

// condition must never hold
`define CLIE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define CLIE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clie_pkg.sv
// shared types, constants and decode functions of the load executor
`timescale 1ns / 1ps
`default_nettype none

package clie_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    localparam t_word PC_RESET     = 16'hFFFC;
    localparam t_byte STATUS_RESET = 8'h24;
    localparam t_byte FLAG_ZERO    = 8'h02;
    localparam t_byte FLAG_NEG     = 8'h80;

    localparam logic [2:0] CYC_ILLEGAL = 3'd1;
    localparam logic [2:0] CYC_IMM     = 3'd2;
    localparam logic [2:0] CYC_ZP      = 3'd3;
    localparam logic [2:0] CYC_IDX     = 3'd4;
    localparam logic [2:0] CYC_ABS     = 3'd4;
    localparam logic [2:0] CYC_CROSS   = 3'd5;

    localparam t_byte OPC_LDA_IMM  = 8'hA9;
    localparam t_byte OPC_LDA_ZP   = 8'hA5;
    localparam t_byte OPC_LDA_ZPX  = 8'hB5;
    localparam t_byte OPC_LDA_ABS  = 8'hAD;
    localparam t_byte OPC_LDA_ABSX = 8'hBD;
    localparam t_byte OPC_LDA_ABSY = 8'hB9;
    localparam t_byte OPC_LDX_IMM  = 8'hA2;
    localparam t_byte OPC_LDX_ZP   = 8'hA6;
    localparam t_byte OPC_LDX_ZPY  = 8'hB6;
    localparam t_byte OPC_LDX_ABS  = 8'hAE;
    localparam t_byte OPC_LDX_ABSY = 8'hBE;
    localparam t_byte OPC_LDY_IMM  = 8'hA0;
    localparam t_byte OPC_LDY_ZP   = 8'hA4;
    localparam t_byte OPC_LDY_ZPX  = 8'hB4;
    localparam t_byte OPC_LDY_ABS  = 8'hAC;
    localparam t_byte OPC_LDY_ABSX = 8'hBC;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXEC  = 2'd1,
        OP_SETPC = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIMPLE,
        ST_OPC,
        ST_ZP,
        ST_LO,
        ST_HI,
        ST_VAL
    } t_state;

    typedef enum logic [2:0] {
        MD_IMM,
        MD_ZP,
        MD_ZPX,
        MD_ZPY,
        MD_ABS,
        MD_ABSX,
        MD_ABSY
    } t_mode;

    typedef enum logic [1:0] {
        DS_A,
        DS_X,
        DS_Y
    } t_dest;

    typedef struct packed {
        logic  legal;
        t_mode mode;
        t_dest dest;
    } t_dec;

    typedef struct packed {
        t_op   operation;
        t_word address;
        t_byte data;
    } t_in;

    typedef struct packed {
        t_byte      accumulator;
        t_byte      index_x;
        t_byte      index_y;
        t_byte      status_flags;
        t_word      program_counter;
        logic [2:0] cycles_used;
        t_word      effective_address;
        logic       illegal_opcode;
    } t_out;

    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        t_word addr;
        t_byte wr_data;
    } t_mem_req;

    function automatic t_dec decode(input t_byte opc);
        t_dec d;
        d.legal = 1'b1;
        d.mode  = MD_IMM;
        d.dest  = DS_A;
        case (opc)
            OPC_LDA_IMM:  begin d.mode = MD_IMM;  d.dest = DS_A; end
            OPC_LDA_ZP:   begin d.mode = MD_ZP;   d.dest = DS_A; end
            OPC_LDA_ZPX:  begin d.mode = MD_ZPX;  d.dest = DS_A; end
            OPC_LDA_ABS:  begin d.mode = MD_ABS;  d.dest = DS_A; end
            OPC_LDA_ABSX: begin d.mode = MD_ABSX; d.dest = DS_A; end
            OPC_LDA_ABSY: begin d.mode = MD_ABSY; d.dest = DS_A; end
            OPC_LDX_IMM:  begin d.mode = MD_IMM;  d.dest = DS_X; end
            OPC_LDX_ZP:   begin d.mode = MD_ZP;   d.dest = DS_X; end
            OPC_LDX_ZPY:  begin d.mode = MD_ZPY;  d.dest = DS_X; end
            OPC_LDX_ABS:  begin d.mode = MD_ABS;  d.dest = DS_X; end
            OPC_LDX_ABSY: begin d.mode = MD_ABSY; d.dest = DS_X; end
            OPC_LDY_IMM:  begin d.mode = MD_IMM;  d.dest = DS_Y; end
            OPC_LDY_ZP:   begin d.mode = MD_ZP;   d.dest = DS_Y; end
            OPC_LDY_ZPX:  begin d.mode = MD_ZPX;  d.dest = DS_Y; end
            OPC_LDY_ABS:  begin d.mode = MD_ABS;  d.dest = DS_Y; end
            OPC_LDY_ABSX: begin d.mode = MD_ABSX; d.dest = DS_Y; end
            default:      d.legal = 1'b0;
        endcase
        return d;
    endfunction

    function automatic t_byte set_nz(input t_byte p, input t_byte v);
        t_byte s;
        s = p & ~(FLAG_ZERO | FLAG_NEG);
        if (v == 8'h00) s = s | FLAG_ZERO;
        if (v[7]) s = s | FLAG_NEG;
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/clie_mem.sv
// byte memory with one shared port, registered read and a clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module clie_mem #(
    parameter int unsigned MEM_BYTES = clie_pkg::MEM_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire clie_pkg::t_mem_req i_req,
    output clie_pkg::t_byte        o_rdata,
    output logic                   o_clearing
);
    import clie_pkg::*;

    localparam int unsigned AW = $clog2(MEM_BYTES);

    t_byte            r_mem [MEM_BYTES];
    t_byte            r_rdata;
    logic [AW-1:0]    r_clr_idx;
    logic             r_clearing;
    logic [AW-1:0]    idx;

    // addresses wrap modulo the memory size
    if ((MEM_BYTES & (MEM_BYTES - 1)) == 0) begin : g_mask
        assign idx = i_req.addr[AW-1:0];
    end else begin : g_recip
        // quotient of a 16-bit address by reciprocal multiplication, kept to 8 bits: exact for MEM_BYTES above 256
        localparam int unsigned SH    = 16 + AW;
        localparam logic [16:0] RECIP =
            17'(((64'd1 << SH) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));

        logic [32:0] prod;
        logic [7:0]  quo;
        logic [16:0] rem;

        assign prod = {17'd0, i_req.addr} * {16'd0, RECIP};
        assign quo  = 8'(prod >> SH);
        assign rem  = {1'b0, i_req.addr} - {9'd0, quo} * 17'(MEM_BYTES);
        assign idx  = rem[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(MEM_BYTES - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= 8'h00;
        end else if (i_req.wr_en) begin
            r_mem[idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) r_rdata <= r_mem[idx];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// File: rtl/cpu_load_instruction_executor.sv
// top level of the load-instruction executor: sequencer, registers and result stage
//
//  channel  direction  handshake                payload
//  in       into block i_in_valid / o_in_stall  i_in  (operation, address, data)
//  out      from block o_out_valid / i_out_stall o_out (registers, cycles, address, illegal)
//
// a write, set-pc or no-op transaction can be taken every cycle while the output is not stalled. an
// execute transaction reads one byte per cycle over the single memory port: opcode, then the
// immediate value, the zero-page address and value, or two address bytes and the value; an
// illegal opcode gives its result from the opcode state. the next transaction is taken in the
// result cycle. after reset the memory is swept to zero; the input stalls until the sweep ends.
// a stalled output holds the sequencer in its result state; the input stalls with it.
`timescale 1ns / 1ps
`default_nettype none
`include "cpu_load_instruction_executor_defines.svh"

module cpu_load_instruction_executor #(
    parameter int unsigned MEM_BYTES = clie_pkg::MEM_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire clie_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output clie_pkg::t_out    o_out
);
    import clie_pkg::*;

    // sequencer and architectural registers
    t_state     r_state, n_state;
    t_byte      r_a, n_a;
    t_byte      r_x, n_x;
    t_byte      r_y, n_y;
    t_byte      r_p, n_p;
    t_word      r_pc, n_pc;

    // per-instruction working registers
    t_mode      r_mode, n_mode;
    t_dest      r_dest, n_dest;
    t_byte      r_lo, n_lo;
    t_word      r_ea, n_ea;
    logic [2:0] r_cyc, n_cyc;

    // result register
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    t_mem_req   mem_req;
    t_byte      mem_rdata;
    logic       mem_clearing;

    t_dec       dec;
    logic       out_free;
    logic       ready;
    logic       in_acc;
    t_state     acc_state;
    t_byte      idx;
    t_byte      zp;
    t_word      base;
    t_word      ea;

    clie_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (mem_rdata),
        .o_clearing (mem_clearing)
    );

    // opcode decode straight off the memory read register
    assign dec = decode(mem_rdata);

    // result stage can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // the input is taken when idle or in the cycle a result leaves the sequencer
    always_comb begin
        case (r_state)
            ST_IDLE, ST_SIMPLE, ST_VAL: ready = out_free;
            ST_OPC:                     ready = out_free && !dec.legal;
            default:                    ready = 1'b0;
        endcase
    end

    assign o_in_stall = !ready;
    assign in_acc     = i_in_valid && ready;
    assign acc_state  = !in_acc ? ST_IDLE :
                        (i_in.operation == OP_EXEC) ? ST_OPC : ST_SIMPLE;

    // index register picked by the addressing mode
    always_comb begin
        if (r_mode inside {MD_ZPX, MD_ABSX}) begin
            idx = r_x;
        end else if (r_mode inside {MD_ZPY, MD_ABSY}) begin
            idx = r_y;
        end else begin
            idx = 8'h00;
        end
    end

    assign zp   = mem_rdata + idx;                 // zero page wraps at 8 bits
    assign base = {mem_rdata, r_lo};
    assign ea   = base + {8'h00, idx};             // absolute wraps at 16 bits

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (!mem_clearing) n_state = ST_IDLE;
            end
            ST_IDLE, ST_SIMPLE, ST_VAL: begin
                if (out_free) n_state = acc_state;
            end
            ST_OPC: begin
                if (!dec.legal) begin
                    if (out_free) n_state = acc_state;
                end else if (dec.mode == MD_IMM) begin
                    n_state = ST_VAL;
                end else if (dec.mode inside {MD_ZP, MD_ZPX, MD_ZPY}) begin
                    n_state = ST_ZP;
                end else begin
                    n_state = ST_LO;
                end
            end
            ST_ZP:   n_state = ST_VAL;
            ST_LO:   n_state = ST_HI;
            ST_HI:   n_state = ST_VAL;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory requests, register updates and result
    always_comb begin
        mem_req     = '0;
        n_a         = r_a;
        n_x         = r_x;
        n_y         = r_y;
        n_p         = r_p;
        n_pc        = r_pc;
        n_mode      = r_mode;
        n_dest      = r_dest;
        n_lo        = r_lo;
        n_ea        = r_ea;
        n_cyc       = r_cyc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        // accepted transaction: writes and pc loads act at once, execute fetches the opcode
        if (in_acc) begin
            case (i_in.operation)
                OP_WRITE: begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.addr    = i_in.address;
                    mem_req.wr_data = i_in.data;
                end
                OP_SETPC: n_pc = i_in.address;
                OP_EXEC: begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = r_pc;
                    n_pc          = r_pc + 16'd1;
                end
                OP_NOP:  ;
                default: ;
            endcase
        end

        case (r_state)
            ST_SIMPLE: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.accumulator       = r_a;
                    n_out.index_x           = r_x;
                    n_out.index_y           = r_y;
                    n_out.status_flags      = r_p;
                    n_out.program_counter   = r_pc;
                    n_out.cycles_used       = 3'd0;
                    n_out.effective_address = 16'h0000;
                    n_out.illegal_opcode    = 1'b0;
                end
            end
            ST_OPC: begin
                if (!dec.legal) begin
                    // unimplemented opcode: pc already past it, registers kept
                    if (out_free) begin
                        n_out_valid             = 1'b1;
                        n_out.accumulator       = r_a;
                        n_out.index_x           = r_x;
                        n_out.index_y           = r_y;
                        n_out.status_flags      = r_p;
                        n_out.program_counter   = r_pc;
                        n_out.cycles_used       = CYC_ILLEGAL;
                        n_out.effective_address = 16'h0000;
                        n_out.illegal_opcode    = 1'b1;
                    end
                end else begin
                    n_mode        = dec.mode;
                    n_dest        = dec.dest;
                    n_ea          = 16'h0000;
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = r_pc;
                    n_pc          = r_pc + 16'd1;
                    case (dec.mode)
                        MD_IMM:                            n_cyc = CYC_IMM;
                        MD_ZP:                             n_cyc = CYC_ZP;
                        MD_ZPX, MD_ZPY:                    n_cyc = CYC_IDX;
                        MD_ABS, MD_ABSX, MD_ABSY:          n_cyc = CYC_ABS;
                        default:                           n_cyc = CYC_ABS;
                    endcase
                end
            end
            ST_ZP: begin
                n_ea          = {8'h00, zp};
                mem_req.rd_en = 1'b1;
                mem_req.addr  = {8'h00, zp};
            end
            ST_LO: begin
                n_lo          = mem_rdata;
                mem_req.rd_en = 1'b1;
                mem_req.addr  = r_pc;
                n_pc          = r_pc + 16'd1;
            end
            ST_HI: begin
                // cycles_used takes CYC_CROSS only when indexing moves into another page
                if (ea[15:8] != mem_rdata) n_cyc = CYC_CROSS;
                n_ea          = ea;
                mem_req.rd_en = 1'b1;
                mem_req.addr  = ea;
            end
            ST_VAL: begin
                if (out_free) begin
                    case (r_dest)
                        DS_A:    n_a = mem_rdata;
                        DS_X:    n_x = mem_rdata;
                        DS_Y:    n_y = mem_rdata;
                        default: n_a = mem_rdata;
                    endcase
                    n_p                     = set_nz(r_p, mem_rdata);
                    n_out_valid             = 1'b1;
                    n_out.accumulator       = n_a;
                    n_out.index_x           = n_x;
                    n_out.index_y           = n_y;
                    n_out.status_flags      = n_p;
                    n_out.program_counter   = r_pc;
                    n_out.cycles_used       = r_cyc;
                    n_out.effective_address = r_ea;
                    n_out.illegal_opcode    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_a         <= 8'h00;
            r_x         <= 8'h00;
            r_y         <= 8'h00;
            r_p         <= STATUS_RESET;
            r_pc        <= PC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_x         <= n_x;
            r_y         <= n_y;
            r_p         <= n_p;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_dest <= n_dest;
        r_lo   <= n_lo;
        r_ea   <= n_ea;
        r_cyc  <= n_cyc;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `CLIE_ASSERT_IMPL(a_stall_in_clear, r_state == ST_CLEAR, o_in_stall, "input taken during memory clear")
    `CLIE_ASSERT_NEVER(a_one_port, mem_req.rd_en && mem_req.wr_en, "memory read and write in one cycle")
    `CLIE_ASSERT_NEXT(a_exec_fetch, in_acc && (i_in.operation == OP_EXEC), r_state == ST_OPC, "execute did not go to opcode fetch")
    `CLIE_ASSERT_IMPL(a_illegal_out, r_out_valid && r_out.illegal_opcode, (r_out.cycles_used == CYC_ILLEGAL) && (r_out.effective_address == 16'h0000), "bad illegal-opcode result")

endmodule

`default_nettype wire
